### rtl/core/tstab_pkg.sv
// Shared types and constants for the time-sorted table.
`default_nettype none
package tstab_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int MAX_RESULTS = 16;
  localparam int TAG_W       = 8;
  localparam int TIME_W      = 32;
  localparam int SIZE_W      = 20;
  localparam int LIMIT_W     = 24;
  localparam int OUT_TOT_W   = 24;
  localparam int OUT_CNT_W   = 5;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int NEV_W       = $clog2(MAX_RESULTS + 1);
  localparam int TOTAL_W     = (SIZE_W + CNT_W > LIMIT_W) ? SIZE_W + CNT_W : LIMIT_W;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(32768);

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_EVICTED  = 2'd1,
    ST_FULL     = 2'd2,
    ST_NONE     = 2'd3
  } status_e;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] tim;
    logic [SIZE_W-1:0] size;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic               valid;
    status_e            status;
    entry_t             ent;
    logic [TOTAL_W-1:0] total;
    logic [CNT_W-1:0]   count;
    logic               last;
  } result_t;

endpackage
`default_nettype wire

### rtl/core/tstab_mem.sv
// Entry store: one write port, one registered read port.
`default_nettype none
module tstab_mem (
  input  wire logic              clk_i,
  input  wire tstab_pkg::mem_req_t req_i,
  output tstab_pkg::entry_t      rdata_o
);
  import tstab_pkg::*;

  entry_t mem_q [TABLE_DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### rtl/core/tstab_ctrl.sv
// Sequencer for insert shifts, minimum scans and eviction shifts.
`default_nettype none
module tstab_ctrl (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic                                opcode_i,
  input  wire logic [tstab_pkg::TAG_W-1:0]         file_tag_i,
  input  wire logic [tstab_pkg::TIME_W-1:0]        file_time_i,
  input  wire logic [tstab_pkg::SIZE_W-1:0]        file_size_i,
  input  wire logic [tstab_pkg::LIMIT_W-1:0]       limit_i,
  output logic                                     busy_o,
  output tstab_pkg::mem_req_t                      mem_req_o,
  input  wire tstab_pkg::entry_t                   mem_rdata_i,
  output tstab_pkg::result_t                       res_o
);
  import tstab_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_INS_RD   = 7'b0000010,
    S_INS_CMP  = 7'b0000100,
    S_SCAN_RD  = 7'b0001000,
    S_SCAN_CMP = 7'b0010000,
    S_SHF_RD   = 7'b0100000,
    S_SHF_WR   = 7'b1000000
  } state_e;

  state_e             state_q, state_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic [NEV_W-1:0]   nevict_q, nevict_d;
  entry_t             new_q, new_d;
  entry_t             best_q, best_d;
  logic [IDX_W-1:0]   best_idx_q, best_idx_d;
  result_t            res_q, res_d;

  logic [TOTAL_W-1:0] lim;
  logic [CNT_W-1:0]   idx_next;
  logic [CNT_W-1:0]   cnt_dec;
  logic [TOTAL_W-1:0] tot_dec;
  logic               more;
  logic               over;

  assign lim      = TOTAL_W'(limit_i);
  assign idx_next = CNT_W'(idx_q) + CNT_W'(1);
  assign cnt_dec  = count_q - CNT_W'(1);
  assign tot_dec  = total_q - TOTAL_W'(best_q.size);
  assign more     = (cnt_dec != '0) && (tot_dec > lim) &&
                    ((nevict_q + NEV_W'(1)) < NEV_W'(MAX_RESULTS));
  assign over     = (count_q != '0) && (total_q > lim);

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    count_d    = count_q;
    total_d    = total_q;
    nevict_d   = nevict_q;
    new_d      = new_q;
    best_d     = best_q;
    best_idx_d = best_idx_q;
    res_d      = res_q;
    res_d.valid = 1'b0;

    mem_req_o       = '0;
    mem_req_o.raddr = idx_q;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (!opcode_i) begin
            if (count_q == CNT_W'(TABLE_DEPTH)) begin
              res_d.valid  = 1'b1;
              res_d.status = ST_FULL;
              res_d.ent    = '0;
              res_d.total  = total_q;
              res_d.count  = count_q;
              res_d.last   = 1'b1;
            end else begin
              new_d.tag  = file_tag_i;
              new_d.tim  = file_time_i;
              new_d.size = file_size_i;
              idx_d      = IDX_W'(count_q);
              state_d    = S_INS_RD;
            end
          end else if (!over) begin
            res_d.valid  = 1'b1;
            res_d.status = ST_NONE;
            res_d.ent    = '0;
            res_d.total  = total_q;
            res_d.count  = count_q;
            res_d.last   = 1'b1;
          end else begin
            nevict_d = '0;
            idx_d    = '0;
            state_d  = S_SCAN_RD;
          end
        end
      end
      S_INS_RD: begin
        if (idx_q == '0) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = idx_q;
          mem_req_o.wdata = new_q;
          count_d      = count_q + CNT_W'(1);
          total_d      = total_q + TOTAL_W'(new_q.size);
          res_d.valid  = 1'b1;
          res_d.status = ST_INSERTED;
          res_d.ent    = '0;
          res_d.total  = total_d;
          res_d.count  = count_d;
          res_d.last   = 1'b1;
          state_d      = S_IDLE;
        end else begin
          mem_req_o.raddr = idx_q - IDX_W'(1);
          state_d         = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = idx_q;
        if ($signed(mem_rdata_i.tim) > $signed(new_q.tim)) begin
          mem_req_o.wdata = mem_rdata_i;
          idx_d           = idx_q - IDX_W'(1);
          state_d         = S_INS_RD;
        end else begin
          mem_req_o.wdata = new_q;
          count_d      = count_q + CNT_W'(1);
          total_d      = total_q + TOTAL_W'(new_q.size);
          res_d.valid  = 1'b1;
          res_d.status = ST_INSERTED;
          res_d.ent    = '0;
          res_d.total  = total_d;
          res_d.count  = count_d;
          res_d.last   = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_SCAN_RD: begin
        state_d = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if ((idx_q == '0) || (mem_rdata_i.size < best_q.size)) begin
          best_d     = mem_rdata_i;
          best_idx_d = idx_q;
        end
        if (idx_next < count_q) begin
          idx_d   = IDX_W'(idx_next);
          state_d = S_SCAN_RD;
        end else begin
          idx_d   = best_idx_d;
          state_d = S_SHF_RD;
        end
      end
      S_SHF_RD: begin
        if (idx_next < count_q) begin
          mem_req_o.raddr = IDX_W'(idx_next);
          state_d         = S_SHF_WR;
        end else begin
          count_d      = cnt_dec;
          total_d      = tot_dec;
          nevict_d     = nevict_q + NEV_W'(1);
          res_d.valid  = 1'b1;
          res_d.status = ST_EVICTED;
          res_d.ent    = best_q;
          res_d.total  = tot_dec;
          res_d.count  = cnt_dec;
          res_d.last   = !more;
          idx_d        = '0;
          state_d      = more ? S_SCAN_RD : S_IDLE;
        end
      end
      S_SHF_WR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = idx_q;
        mem_req_o.wdata = mem_rdata_i;
        idx_d           = IDX_W'(idx_next);
        state_d         = S_SHF_RD;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      total_q   <= '0;
      res_q     <= '0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      total_q   <= total_d;
      res_q     <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    nevict_q   <= nevict_d;
    new_q      <= new_d;
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign res_o  = res_q;

endmodule
`default_nettype wire

### rtl/core/time_sorted_table_with_size_eviction_unit.sv
// Top level: time-sorted table with size-based eviction.
// Insert: entries with a later time are read and shifted up one place, then the new entry is written; one result beat.
// Trim: each eviction scans the entries for the smallest size, then shifts the later entries down;
//   at most 16 eviction beats; an idle trim or a full-table insert answers next cycle.
// busy is high while the table is walked; each beat shows the cycle after it is formed.
// Reset empties the table and sets the capacity limit to 32768; no clearing pass.
`default_nettype none
module time_sorted_table_with_size_eviction_unit (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic                                opcode_i,
  input  wire logic [tstab_pkg::TAG_W-1:0]         file_tag_i,
  input  wire logic [tstab_pkg::TIME_W-1:0]        file_time_i,
  input  wire logic [tstab_pkg::SIZE_W-1:0]        file_size_i,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [tstab_pkg::LIMIT_W-1:0]       cfg_data_i,
  output logic                                     result_valid_o,
  output logic [1:0]                               status_o,
  output logic [tstab_pkg::TAG_W-1:0]              evicted_tag_o,
  output logic [tstab_pkg::TIME_W-1:0]             evicted_time_o,
  output logic [tstab_pkg::SIZE_W-1:0]             evicted_size_o,
  output logic [tstab_pkg::OUT_TOT_W-1:0]          total_size_o,
  output logic [tstab_pkg::OUT_CNT_W-1:0]          entry_count_o,
  output logic                                     last_o
);
  import tstab_pkg::*;

  logic [LIMIT_W-1:0] limit_q;
  mem_req_t           mem_req;
  entry_t             mem_rdata;
  result_t            res;
  logic               busy_w;

  localparam int CNT_CMP_W = (CNT_W > OUT_CNT_W) ? CNT_W : OUT_CNT_W;
  localparam int TOT_CMP_W = (TOTAL_W > OUT_TOT_W) ? TOTAL_W : OUT_TOT_W;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      limit_q <= cfg_data_i;
    end
  end

  tstab_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start && !busy_w),
    .opcode_i    (opcode_i),
    .file_tag_i  (file_tag_i),
    .file_time_i (file_time_i),
    .file_size_i (file_size_i),
    .limit_i     (limit_q),
    .busy_o      (busy_w),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata),
    .res_o       (res)
  );

  tstab_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  assign busy           = busy_w;
  assign result_valid_o = res.valid;
  assign status_o       = res.status;
  assign evicted_tag_o  = res.ent.tag;
  assign evicted_time_o = res.ent.tim;
  assign evicted_size_o = res.ent.size;
  assign last_o         = res.last;

  // saturate on deep tables
  assign total_size_o = (TOT_CMP_W'(res.total) > TOT_CMP_W'({OUT_TOT_W{1'b1}})) ?
                        {OUT_TOT_W{1'b1}} : OUT_TOT_W'(res.total);
  assign entry_count_o = (CNT_CMP_W'(res.count) > CNT_CMP_W'({OUT_CNT_W{1'b1}})) ?
                         {OUT_CNT_W{1'b1}} : OUT_CNT_W'(res.count);

endmodule
`default_nettype wire

### tb/sv/testbench.sv
// Testbench for the time-sorted table: directed and random inserts and trims against a predictor.
module testbench;
  import tstab_pkg::*;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_TRIM   = 1'b1;
  localparam int   CYCLE_LIMIT = 500_000;
  localparam int   RANDOM_ITEMS = 420;

  typedef struct {
    status_e               status;
    logic [TAG_W-1:0]      tag;
    logic [TIME_W-1:0]     tim;
    logic [SIZE_W-1:0]     size;
    logic [OUT_TOT_W-1:0]  total;
    logic [OUT_CNT_W-1:0]  count;
    logic                  last;
  } table_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 opcode_i = OP_INSERT;
  logic [TAG_W-1:0]     file_tag_i = '0;
  logic [TIME_W-1:0]    file_time_i = '0;
  logic [SIZE_W-1:0]    file_size_i = '0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [LIMIT_W-1:0]   cfg_data_i = '0;
  logic                 result_valid_o;
  logic [1:0]           status_o;
  logic [TAG_W-1:0]     evicted_tag_o;
  logic [TIME_W-1:0]    evicted_time_o;
  logic [SIZE_W-1:0]    evicted_size_o;
  logic [OUT_TOT_W-1:0] total_size_o;
  logic [OUT_CNT_W-1:0] entry_count_o;
  logic                 last_o;

  // Shadow copy of the table and its limit
  entry_t             shadow_entries[TABLE_DEPTH];
  int                 shadow_count = 0;
  longint unsigned    shadow_total = 0;
  logic [LIMIT_W-1:0] shadow_limit = LIMIT_RESET;

  table_result_t awaited_results[$];

  int  n_items = 0;
  int  n_results = 0;
  int  n_evictions = 0;
  int  n_full = 0;
  int  n_limit_writes = 0;
  int  n_errors = 0;
  int  cycles = 0;
  bit  idling = 1'b1;

  time_sorted_table_with_size_eviction_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .opcode_i       (opcode_i),
    .file_tag_i     (file_tag_i),
    .file_time_i    (file_time_i),
    .file_size_i    (file_size_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .evicted_tag_o  (evicted_tag_o),
    .evicted_time_o (evicted_time_o),
    .evicted_size_o (evicted_size_o),
    .total_size_o   (total_size_o),
    .entry_count_o  (entry_count_o),
    .last_o         (last_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic void push_expected(status_e st, entry_t ent, logic fin);
    table_result_t r;
    r.status = st;
    r.tag    = ent.tag;
    r.tim    = ent.tim;
    r.size   = ent.size;
    r.total  = (shadow_total > 64'hFF_FFFF) ? '1 : OUT_TOT_W'(shadow_total);
    r.count  = (shadow_count > 31) ? 5'd31 : OUT_CNT_W'(shadow_count);
    r.last   = fin;
    awaited_results.push_back(r);
  endfunction

  function automatic void predict_table_step(logic op, entry_t item);
    int pos;
    int best;
    int n;
    entry_t victim;
    if (op == OP_INSERT) begin
      if (shadow_count >= TABLE_DEPTH) begin
        n_full++;
        push_expected(ST_FULL, '0, 1'b1);
        return;
      end
      pos = 0;
      while (pos < shadow_count && $signed(shadow_entries[pos].tim) <= $signed(item.tim))
        pos++;
      for (int i = shadow_count; i > pos; i--)
        shadow_entries[i] = shadow_entries[i-1];
      shadow_entries[pos] = item;
      shadow_count++;
      shadow_total += item.size;
      push_expected(ST_INSERTED, '0, 1'b1);
      return;
    end
    n = 0;
    while (n < MAX_RESULTS && shadow_count > 0 && shadow_total > shadow_limit) begin
      best = 0;
      for (int i = 1; i < shadow_count; i++)
        if (shadow_entries[i].size < shadow_entries[best].size)
          best = i;
      victim = shadow_entries[best];
      for (int i = best; i + 1 < shadow_count; i++)
        shadow_entries[i] = shadow_entries[i+1];
      shadow_count--;
      shadow_total -= victim.size;
      n++;
      n_evictions++;
      push_expected(ST_EVICTED, victim,
                    !(n < MAX_RESULTS && shadow_count > 0 && shadow_total > shadow_limit));
    end
    if (n == 0)
      push_expected(ST_NONE, '0, 1'b1);
  endfunction

  always @(posedge clk_i) begin : check_results
    table_result_t want;
    if (rst_ni && result_valid_o) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected result beat, status %0d", status_o);
        n_errors++;
      end else begin
        want = awaited_results.pop_front();
        n_results++;
        if (status_o !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status_o);
          n_errors++;
        end
        if (evicted_tag_o !== want.tag) begin
          $error("evicted_tag: expected %0d, actual %0d", want.tag, evicted_tag_o);
          n_errors++;
        end
        if (evicted_time_o !== want.tim) begin
          $error("evicted_time: expected %0d, actual %0d",
                 $signed(want.tim), $signed(evicted_time_o));
          n_errors++;
        end
        if (evicted_size_o !== want.size) begin
          $error("evicted_size: expected %0d, actual %0d", want.size, evicted_size_o);
          n_errors++;
        end
        if (total_size_o !== want.total) begin
          $error("total_size: expected %0d, actual %0d", want.total, total_size_o);
          n_errors++;
        end
        if (entry_count_o !== want.count) begin
          $error("entry_count: expected %0d, actual %0d", want.count, entry_count_o);
          n_errors++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, last_o);
          n_errors++;
        end
      end
    end
  end

  function automatic int idle_gap();
    int r;
    if (!idling)
      return 0;
    r = $urandom_range(99);
    if (r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Called just after a rising edge; returns on the edge that takes the beat.
  task automatic send_item(logic op, logic [TAG_W-1:0] tag, logic [TIME_W-1:0] tim,
                           logic [SIZE_W-1:0] size);
    int gap;
    entry_t item;
    gap = idle_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start       <= 1'b1;
    opcode_i    <= op;
    file_tag_i  <= tag;
    file_time_i <= tim;
    file_size_i <= size;
    do @(posedge clk_i); while (busy);
    item.tag  = tag;
    item.tim  = tim;
    item.size = size;
    predict_table_step(op, item);
    n_items++;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk_i); while (busy || awaited_results.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_capacity_limit(logic [LIMIT_W-1:0] value);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    shadow_limit = value;
    n_limit_writes++;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 8)
      return '0;
    if (r < 14)
      return '1;
    if (r < 24)
      return SIZE_W'($urandom);
    return SIZE_W'($urandom_range(1, 8191));
  endfunction

  function automatic logic [TIME_W-1:0] pick_time();
    int r;
    r = $urandom_range(99);
    if (r < 20)
      return TIME_W'($urandom_range(0, 4) - 2);
    if (r < 23)
      return 32'h8000_0000;
    if (r < 26)
      return 32'h7FFF_FFFF;
    return $urandom;
  endfunction

  function automatic logic [LIMIT_W-1:0] pick_limit();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return LIMIT_RESET;
      3: return LIMIT_W'($urandom);
      default: return LIMIT_W'($urandom_range(0, 60000));
    endcase
  endfunction

  task automatic test_empty_trim();
    send_item(OP_TRIM, 8'h00, '0, '0);
  endtask

  // Extremes of time and size, equal times and equal sizes, then a trim at the reset limit
  task automatic test_insert_order();
    send_item(OP_INSERT, 8'hFF, 32'h7FFF_FFFF, 20'hF_FFFF);
    send_item(OP_INSERT, 8'h00, 32'h8000_0000, 20'h0_0000);
    send_item(OP_INSERT, 8'h01, 32'h0000_0000, 20'd100);
    send_item(OP_INSERT, 8'h02, 32'h0000_0000, 20'd100);
    send_item(OP_INSERT, 8'h03, 32'hFFFF_FFFF, 20'd100);
    send_item(OP_TRIM, 8'hAA, 32'h5555_5555, 20'hA_AAAA);
  endtask

  // Fill to depth, refuse one more, no-op trim at the top limit, then evict all in one trim
  task automatic test_full_table();
    write_capacity_limit('1);
    for (int i = 0; i < TABLE_DEPTH; i++)
      send_item(OP_INSERT, TAG_W'(i + 16), pick_time(), SIZE_W'(i % 3 + 1));
    send_item(OP_INSERT, 8'h5A, $urandom, 20'd7);
    send_item(OP_TRIM, '0, '0, '0);
    write_capacity_limit('0);
    send_item(OP_TRIM, '0, '0, '0);
  endtask

  task automatic test_random_traffic();
    int sent;
    int phase_items;
    int burst;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      write_capacity_limit(pick_limit());
      idling = ($urandom_range(3) != 0);
      phase_items = $urandom_range(20, 40);
      while (phase_items > 0 && sent < RANDOM_ITEMS) begin
        if ($urandom_range(9) < 7) begin
          burst = $urandom_range(1, 10);
          repeat (burst)
            send_item(OP_INSERT, TAG_W'($urandom), pick_time(), pick_size());
          send_item(OP_TRIM, TAG_W'($urandom), $urandom, SIZE_W'($urandom));
          sent += burst + 1;
          phase_items -= burst + 1;
        end else begin
          send_item(1'($urandom), TAG_W'($urandom), $urandom, SIZE_W'($urandom));
          sent++;
          phase_items--;
        end
      end
    end
    idling = 1'b1;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_trim();
    test_insert_order();
    test_full_table();
    test_random_traffic();
    wait_idle();
    repeat (40) @(posedge clk_i);
    $display("Sent %0d items over %0d limit settings; checked %0d results.",
             n_items, n_limit_writes, n_results);
    $display("Seen %0d evictions and %0d refused inserts on a full table.",
             n_evictions, n_full);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### time_sorted_table_with_size_eviction_unit.f
rtl/core/tstab_pkg.sv
rtl/core/tstab_mem.sv
rtl/core/tstab_ctrl.sv
rtl/core/time_sorted_table_with_size_eviction_unit.sv
tb/sv/testbench.sv
